### sv/clock_page_replacement_defines.svh
// ----------------------------------------------------------------------------
// clock_page_replacement_defines.svh
// Assertion macros shared by the clock page replacement block.
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while in reset
`define CPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while in reset
`define CPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Types, codes and helpers of the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // Frame table size and derived widths
  localparam int FRAMES     = 32;
  localparam int SLOT_W     = $clog2(FRAMES);
  localparam int FIFO_DEPTH = 2;

  // Request field widths
  localparam int OP_W   = 3;
  localparam int SLOTF_W = 5;
  localparam int KIND_W = 2;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_TOUCH  = 3'd2,
    OP_PIN    = 3'd3,
    OP_EVICT  = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXEC = 2'd0,
    KIND_FILE = 2'd1,
    KIND_ANON = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_PINNED  = 2'd2,
    ST_BADSLOT = 2'd3
  } status_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_DISCARD = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_SWAP    = 2'd2
  } action_e;

  // Classified command handed from front to back
  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_TOUCH   = 3'd2,
    CMD_PIN     = 3'd3,
    CMD_EVICT   = 3'd4,
    CMD_BADSLOT = 3'd5,
    CMD_NOP     = 3'd6
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [SLOTF_W-1:0] slot;
    logic [KIND_W-1:0] kind;
    logic              is_write;
    logic              pin_value;
  } cmd_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic scanning;
    logic hand_started;
  } bk_stat_t;

  // Eviction action from page kind and dirty mark
  function automatic action_e action_for(logic [KIND_W-1:0] kind, logic dirty);
    action_e act;
    act = ACT_DISCARD;
    if (kind == KIND_FILE && dirty) begin
      act = ACT_WRITE;
    end else if (kind == KIND_ANON || (kind == KIND_EXEC && dirty)) begin
      act = ACT_SWAP;
    end
    return act;
  endfunction

endpackage

### sv/cpr_if.sv
// ----------------------------------------------------------------------------
// cpr_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpr_req_if;
  import cpr_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [SLOTF_W-1:0] slot;
  logic [KIND_W-1:0]  page_kind;
  logic               is_write;
  logic               pin_value;

  modport source (output valid, output op, output slot, output page_kind,
                  output is_write, output pin_value, input ready);
  modport sink   (input valid, input op, input slot, input page_kind,
                  input is_write, input pin_value, output ready);
endinterface

interface cpr_rsp_if;
  import cpr_pkg::*;

  logic               valid;
  logic               ready;
  logic [SLOTF_W-1:0] victim_slot;
  logic [ACT_W-1:0]   action;
  logic [STAT_W-1:0]  status;

  modport source (output valid, output victim_slot, output action,
                  output status, input ready);
  modport sink   (input valid, input victim_slot, input action,
                  input status, output ready);
endinterface

### sv/cpr_front.sv
// ----------------------------------------------------------------------------
// cpr_front
// Accepts requests and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module cpr_front (
  cpr_req_if.sink      req_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output cpr_pkg::cmd_t push_data_o
);
  import cpr_pkg::*;

  logic in_range;

  // Slots past the table are rejected up front
  assign in_range = int'(req_i.slot) < FRAMES;

  assign req_i.ready  = push_ready_i;
  assign push_valid_o = req_i.valid;

  // Classify op code and slot range
  always_comb begin
    push_data_o.slot      = req_i.slot;
    push_data_o.kind      = req_i.page_kind;
    push_data_o.is_write  = req_i.is_write;
    push_data_o.pin_value = req_i.pin_value;
    case (req_i.op)
      OP_INSERT: push_data_o.cmd = in_range ? CMD_INSERT : CMD_BADSLOT;
      OP_REMOVE: push_data_o.cmd = in_range ? CMD_REMOVE : CMD_BADSLOT;
      OP_TOUCH:  push_data_o.cmd = in_range ? CMD_TOUCH  : CMD_BADSLOT;
      OP_PIN:    push_data_o.cmd = in_range ? CMD_PIN    : CMD_BADSLOT;
      OP_EVICT:  push_data_o.cmd = CMD_EVICT;
      default:   push_data_o.cmd = CMD_NOP;
    endcase
  end

endmodule

### sv/cpr_fifo.sv
// ----------------------------------------------------------------------------
// cpr_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module cpr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  cpr_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output cpr_pkg::cmd_t pop_data_o
);
  import cpr_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != CNT_W'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and count update with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/cpr_back.sv
// ----------------------------------------------------------------------------
// cpr_back
// Frame table, clock hand and eviction scan; registers one response.
// ----------------------------------------------------------------------------
module cpr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  cpr_pkg::cmd_t    pop_data_i,
  cpr_rsp_if.source        rsp_o,
  output cpr_pkg::bk_stat_t stat_o
);
  import cpr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_q, state_d;
  logic [FRAMES-1:0] valid_q, valid_d;
  logic [FRAMES-1:0] pinned_q, pinned_d;
  logic [FRAMES-1:0] acc_q, acc_d;
  logic [FRAMES-1:0] dirty_q, dirty_d;
  logic [KIND_W-1:0] kind_q [FRAMES];
  logic [SLOT_W-1:0] hand_q, hand_d;
  logic              started_q, started_d;
  logic [SLOT_W-1:0] pos_q, pos_d;

  logic               out_valid_q, out_valid_d;
  logic [SLOTF_W-1:0] out_victim_q, out_victim_d;
  action_e            out_act_q, out_act_d;
  status_e            out_stat_q, out_stat_d;

  logic              out_free;
  logic              kind_we;
  logic [SLOT_W-1:0] cmd_idx;
  logic [SLOT_W-1:0] pos_next;
  logic [SLOT_W-1:0] hand_next;
  logic              any_valid, any_free;

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign cmd_idx   = SLOT_W'(pop_data_i.slot);
  assign pos_next  = (pos_q == SLOT_W'(FRAMES - 1)) ? '0 : pos_q + 1'b1;
  assign hand_next = (hand_q == SLOT_W'(FRAMES - 1)) ? '0 : hand_q + 1'b1;
  assign any_valid = |valid_q;
  assign any_free  = |(valid_q & ~pinned_q);

  assign pop_ready_o = (state_q == S_IDLE) && out_free;
  assign kind_we     = pop_valid_i && pop_ready_o && pop_data_i.cmd == CMD_INSERT;

  // Command execution and scan control
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    pinned_d     = pinned_q;
    acc_d        = acc_q;
    dirty_d      = dirty_q;
    hand_d       = hand_q;
    started_d    = started_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_victim_d = out_victim_q;
    out_act_d    = out_act_q;
    out_stat_d   = out_stat_q;

    case (state_q)
      S_IDLE: begin
        if (pop_valid_i && out_free) begin
          // default response: all zero
          out_valid_d  = 1'b1;
          out_victim_d = '0;
          out_act_d    = ACT_DISCARD;
          out_stat_d   = ST_OK;
          case (pop_data_i.cmd)
            CMD_INSERT: begin
              valid_d[cmd_idx]  = 1'b1;
              pinned_d[cmd_idx] = 1'b0;
              acc_d[cmd_idx]    = 1'b0;
              dirty_d[cmd_idx]  = 1'b0;
            end
            CMD_REMOVE, CMD_TOUCH, CMD_PIN: begin
              if (!valid_q[cmd_idx]) begin
                out_stat_d = ST_BADSLOT;
              end else if (pop_data_i.cmd == CMD_REMOVE) begin
                valid_d[cmd_idx]  = 1'b0;
                pinned_d[cmd_idx] = 1'b0;
                acc_d[cmd_idx]    = 1'b0;
                dirty_d[cmd_idx]  = 1'b0;
              end else if (pop_data_i.cmd == CMD_TOUCH) begin
                acc_d[cmd_idx] = 1'b1;
                if (pop_data_i.is_write) begin
                  dirty_d[cmd_idx] = 1'b1;
                end
              end else begin
                pinned_d[cmd_idx] = pop_data_i.pin_value;
              end
            end
            CMD_EVICT: begin
              if (!any_valid) begin
                out_stat_d = ST_EMPTY;
              end else if (!any_free) begin
                out_stat_d = ST_PINNED;
              end else begin
                // response comes when the scan finds a victim
                out_valid_d = 1'b0;
                state_d     = S_SCAN;
                pos_d       = started_q ? hand_next : '0;
              end
            end
            CMD_BADSLOT: out_stat_d = ST_BADSLOT;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!valid_q[pos_q] || pinned_q[pos_q]) begin
          pos_d = pos_next;
        end else if (acc_q[pos_q]) begin
          // second chance
          acc_d[pos_q] = 1'b0;
          pos_d        = pos_next;
        end else begin
          out_valid_d   = 1'b1;
          out_victim_d  = SLOTF_W'(pos_q);
          out_act_d     = action_for(kind_q[pos_q], dirty_q[pos_q]);
          out_stat_d    = ST_OK;
          valid_d[pos_q]  = 1'b0;
          pinned_d[pos_q] = 1'b0;
          acc_d[pos_q]    = 1'b0;
          dirty_d[pos_q]  = 1'b0;
          hand_d        = pos_q;
          started_d     = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      pinned_q    <= '0;
      acc_q       <= '0;
      dirty_q     <= '0;
      hand_q      <= '0;
      started_q   <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      pinned_q    <= pinned_d;
      acc_q       <= acc_d;
      dirty_q     <= dirty_d;
      hand_q      <= hand_d;
      started_q   <= started_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Response payload and page kinds, no reset
  always_ff @(posedge clk_i) begin
    out_victim_q <= out_victim_d;
    out_act_q    <= out_act_d;
    out_stat_q   <= out_stat_d;
    if (kind_we) begin
      kind_q[cmd_idx] <= pop_data_i.kind;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.victim_slot = out_victim_q;
  assign rsp_o.action      = out_act_q;
  assign rsp_o.status      = out_stat_q;

  assign stat_o.scanning     = state_q == S_SCAN;
  assign stat_o.hand_started = started_q;

endmodule

### sv/clock_page_replacement.sv
// A request is queued on acceptance; its response is registered once the back end takes it.
// Evict adds a scan of one slot per cycle from the slot after the hand, or slot 0 before any evict.
// Throughput: one request per cycle for non-evict ops while responses are taken, set by the single back-end port.
// Reset: all marks, the hand and the queue clear at once; page kinds stay unset, no sweep.
// ----------------------------------------------------------------------------
// clock_page_replacement
// Clock second-chance frame replacement: front classifier, queue, back end.
// ----------------------------------------------------------------------------
`include "clock_page_replacement_defines.svh"

module clock_page_replacement (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpr_req_if.sink   req_i,
  cpr_rsp_if.source rsp_o
);
  import cpr_pkg::*;

  logic     push_valid, push_ready;
  cmd_t     push_data;
  logic     pop_valid, pop_ready;
  cmd_t     pop_data;
  bk_stat_t bk_stat;

  cpr_front u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  cpr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  cpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .rsp_o       (rsp_o),
    .stat_o      (bk_stat)
  );

  // Checks
  `CPR_ASSERT_NOW(a_scan_no_rsp, bk_stat.scanning, !rsp_o.valid, "response during scan")
  `CPR_ASSERT_NEXT(a_req_queued, req_i.valid && req_i.ready, pop_valid, "request lost")
  `CPR_ASSERT_NOW(a_hand_evict, $rose(bk_stat.hand_started),
                  rsp_o.valid && rsp_o.status == ST_OK, "hand placed without victim")
  `CPR_ASSERT_NOW(a_fail_zero,
                  rsp_o.valid && (rsp_o.status == ST_EMPTY || rsp_o.status == ST_PINNED),
                  rsp_o.victim_slot == '0 && rsp_o.action == ACT_DISCARD,
                  "failed evict not zero")

endmodule
